>>> sv/message_fifo_with_timeout_assert.svh
// ----------------------------------------------------------------------------
// message fifo assertion macros
// clocked implication checks used by mft_back
// ----------------------------------------------------------------------------
`ifndef MESSAGE_FIFO_WITH_TIMEOUT_ASSERT_SVH
`define MESSAGE_FIFO_WITH_TIMEOUT_ASSERT_SVH

// same-cycle implication
`define MFT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/mft_pkg.sv
// ----------------------------------------------------------------------------
// mft_pkg
// types, constants and helpers of the message fifo with timeout
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mft_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_BYTES = 64;
  localparam int SLOT_W     = $clog2(SLOT_COUNT);
  localparam int IDX_W      = $clog2(SLOT_BYTES);
  localparam int LEN_W      = $clog2(SLOT_BYTES + 1);
  localparam int ADDR_W     = SLOT_W + IDX_W;
  localparam int MEM_DEPTH  = SLOT_COUNT * (1 << IDX_W);
  localparam int TMO_W      = 32;
  localparam int CQ_DEPTH   = 4;
  localparam int CQ_PTR_W   = $clog2(CQ_DEPTH);
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 48;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_LONG  = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP  = 1'b1;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_LAST,
    CMD_POP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data_byte;
    logic [TMO_W-1:0]  timeout;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_POP
  } back_state_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W-1:0] r;
    if (s == SLOT_W'(SLOT_COUNT - 1)) begin
      r = '0;
    end else begin
      r = s + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage

>>> sv/mft_front.sv
// ----------------------------------------------------------------------------
// mft_front
// takes input transactions and classifies them into back-end commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mft_front (
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mft_pkg::IN_DATA_W-1:0]   s_axis_tdata,  // data_byte, timeout_in
  input  logic                            s_axis_tlast,
  input  logic                            s_axis_tuser,  // func
  output logic                            cmd_valid,
  input  logic                            cmd_ready,
  output mft_pkg::cmd_t                   cmd
);

  assign s_axis_tready = cmd_ready;
  assign cmd_valid     = s_axis_tvalid;

  always_comb begin
    cmd.data_byte = s_axis_tdata[7:0];
    cmd.timeout   = s_axis_tdata[39:8];
    if (s_axis_tuser == mft_pkg::FUNC_POP) begin
      cmd.kind = mft_pkg::CMD_POP;
    end else if (s_axis_tlast) begin
      cmd.kind = mft_pkg::CMD_LAST;
    end else begin
      cmd.kind = mft_pkg::CMD_BYTE;
    end
  end

endmodule

>>> sv/mft_cmd_queue.sv
// ----------------------------------------------------------------------------
// mft_cmd_queue
// short command queue between the front and the back end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mft_cmd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mft_pkg::cmd_t  in_cmd,
  output logic           out_valid,
  input  logic           out_ready,
  output mft_pkg::cmd_t  out_cmd
);

  mft_pkg::cmd_t               entries [mft_pkg::CQ_DEPTH];
  logic [mft_pkg::CQ_PTR_W-1:0] wr_ptr;
  logic [mft_pkg::CQ_PTR_W-1:0] rd_ptr;
  logic [mft_pkg::CQ_PTR_W:0]   count;
  logic                         push;
  logic                         pop;

  assign in_ready  = (count != (mft_pkg::CQ_PTR_W + 1)'(mft_pkg::CQ_DEPTH));
  assign out_valid = (count != '0);
  assign out_cmd   = entries[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + mft_pkg::CQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + mft_pkg::CQ_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (mft_pkg::CQ_PTR_W + 1)'(1);
        2'b01:   count <= count - (mft_pkg::CQ_PTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/mft_back.sv
// ----------------------------------------------------------------------------
// mft_back
// message store, slot pointers and the result output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "message_fifo_with_timeout_assert.svh"

module mft_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_ready,
  input  mft_pkg::cmd_t                    cmd,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [mft_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // out_byte, msg_length, msg_timeout
  output logic                             m_axis_tlast,
  output logic [1:0]                       m_axis_tuser   // status
);

  localparam int SW = mft_pkg::SLOT_W;
  localparam int IW = mft_pkg::IDX_W;
  localparam int LW = mft_pkg::LEN_W;
  localparam int TW = mft_pkg::TMO_W;

  logic [7:0]    byte_mem     [mft_pkg::MEM_DEPTH];
  logic [LW-1:0] slot_length  [mft_pkg::SLOT_COUNT];
  logic [TW-1:0] slot_timeout [mft_pkg::SLOT_COUNT];

  mft_pkg::back_state_t state, state_next;
  logic [SW-1:0] head_slot, head_slot_next;
  logic [SW-1:0] tail_slot, tail_slot_next;
  logic          queue_empty, queue_empty_next;
  logic          queue_full, queue_full_next;
  logic [LW-1:0] bytes_gathered, bytes_gathered_next;
  logic [1:0]    push_rejected, push_rejected_next;
  logic [IW-1:0] pop_idx, pop_idx_next;
  logic [LW-1:0] pop_len, pop_len_next;
  logic [TW-1:0] pop_tmo, pop_tmo_next;
  logic [7:0]    rd_data;
  logic [mft_pkg::ADDR_W-1:0] rd_addr;

  logic          out_valid, out_valid_next;
  logic [1:0]    out_status, out_status_next;
  logic [7:0]    out_byte, out_byte_next;
  logic          out_last, out_last_next;
  logic [LW-1:0] out_len, out_len_next;
  logic [TW-1:0] out_tmo, out_tmo_next;

  logic          out_free;
  logic          take;
  logic          pop_end;
  logic          byte_long;
  logic          byte_keep;
  logic [1:0]    rej_new;
  logic [LW-1:0] gath_new;
  logic [1:0]    push_st;
  logic [SW-1:0] tail_commit;
  logic          wr_en;
  logic          commit;

  assign out_free = !out_valid || m_axis_tready;
  assign take     = cmd_valid && cmd_ready;
  assign pop_end  = (LW'(pop_idx) + LW'(1)) == pop_len;

  // byte intake of a push
  assign byte_long = !queue_full && (bytes_gathered >= LW'(mft_pkg::SLOT_BYTES));
  assign byte_keep = !queue_full && !byte_long;
  assign gath_new  = byte_keep ? bytes_gathered + LW'(1) : bytes_gathered;

  always_comb begin
    if (queue_full) begin
      rej_new = mft_pkg::ST_FULL;
    end else if (byte_long && push_rejected != mft_pkg::ST_FULL) begin
      rej_new = mft_pkg::ST_LONG;
    end else begin
      rej_new = push_rejected;
    end
    if (queue_full || rej_new == mft_pkg::ST_FULL) begin
      push_st = mft_pkg::ST_FULL;
    end else if (rej_new == mft_pkg::ST_LONG) begin
      push_st = mft_pkg::ST_LONG;
    end else begin
      push_st = mft_pkg::ST_OK;
    end
  end

  assign tail_commit = queue_empty ? head_slot : tail_slot;

  always_comb begin
    state_next = state;
    case (state)
      mft_pkg::BK_IDLE: begin
        if (take && cmd.kind == mft_pkg::CMD_POP && !queue_empty) begin
          state_next = mft_pkg::BK_POP;
        end
      end
      mft_pkg::BK_POP: begin
        if (out_free && pop_end) begin
          state_next = mft_pkg::BK_IDLE;
        end
      end
      default: state_next = mft_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_ready = 1'b0;
    case (state)
      mft_pkg::BK_IDLE: begin
        case (cmd.kind)
          mft_pkg::CMD_BYTE: cmd_ready = 1'b1;
          mft_pkg::CMD_LAST: cmd_ready = out_free;
          mft_pkg::CMD_POP:  cmd_ready = queue_empty ? out_free : 1'b1;
          default:           cmd_ready = 1'b1;
        endcase
      end
      mft_pkg::BK_POP: cmd_ready = 1'b0;
      default:         cmd_ready = 1'b0;
    endcase
  end

  always_comb begin
    head_slot_next      = head_slot;
    tail_slot_next      = tail_slot;
    queue_empty_next    = queue_empty;
    queue_full_next     = queue_full;
    bytes_gathered_next = bytes_gathered;
    push_rejected_next  = push_rejected;
    pop_idx_next        = pop_idx;
    pop_len_next        = pop_len;
    pop_tmo_next        = pop_tmo;
    rd_addr             = {tail_slot, pop_idx};
    wr_en               = 1'b0;
    commit              = 1'b0;
    out_valid_next      = out_valid && !m_axis_tready;
    out_status_next     = out_status;
    out_byte_next       = out_byte;
    out_last_next       = out_last;
    out_len_next        = out_len;
    out_tmo_next        = out_tmo;

    if (state == mft_pkg::BK_IDLE && take) begin
      case (cmd.kind)
        mft_pkg::CMD_BYTE: begin
          wr_en               = byte_keep;
          bytes_gathered_next = gath_new;
          push_rejected_next  = rej_new;
        end
        mft_pkg::CMD_LAST: begin
          wr_en               = byte_keep;
          bytes_gathered_next = '0;
          push_rejected_next  = mft_pkg::ST_OK;
          if (push_st == mft_pkg::ST_OK) begin
            commit           = 1'b1;
            tail_slot_next   = tail_commit;
            queue_empty_next = 1'b0;
            head_slot_next   = mft_pkg::slot_inc(head_slot);
            queue_full_next  = (mft_pkg::slot_inc(head_slot) == tail_commit);
          end
          out_valid_next  = 1'b1;
          out_status_next = push_st;
          out_byte_next   = '0;
          out_last_next   = 1'b1;
          out_len_next    = '0;
          out_tmo_next    = '0;
        end
        mft_pkg::CMD_POP: begin
          if (queue_empty) begin
            out_valid_next  = 1'b1;
            out_status_next = mft_pkg::ST_EMPTY;
            out_byte_next   = '0;
            out_last_next   = 1'b1;
            out_len_next    = '0;
            out_tmo_next    = '0;
          end else begin
            pop_idx_next = '0;
            pop_len_next = slot_length[tail_slot];
            pop_tmo_next = slot_timeout[tail_slot];
            rd_addr      = {tail_slot, IW'(0)};
          end
        end
        default: begin
        end
      endcase
    end else if (state == mft_pkg::BK_POP && out_free) begin
      out_valid_next  = 1'b1;
      out_status_next = mft_pkg::ST_OK;
      out_byte_next   = rd_data;
      out_last_next   = pop_end;
      out_len_next    = pop_len;
      out_tmo_next    = pop_tmo;
      pop_idx_next    = pop_idx + IW'(1);
      rd_addr         = {tail_slot, pop_idx + IW'(1)};
      if (pop_end) begin
        queue_full_next  = 1'b0;
        tail_slot_next   = mft_pkg::slot_inc(tail_slot);
        queue_empty_next = (mft_pkg::slot_inc(tail_slot) == head_slot);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      byte_mem[{head_slot, bytes_gathered[IW-1:0]}] <= cmd.data_byte;
    end
    rd_data <= byte_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      slot_length[head_slot]  <= gath_new;
      slot_timeout[head_slot] <= cmd.timeout;
    end
    pop_idx    <= pop_idx_next;
    pop_len    <= pop_len_next;
    pop_tmo    <= pop_tmo_next;
    out_status <= out_status_next;
    out_byte   <= out_byte_next;
    out_last   <= out_last_next;
    out_len    <= out_len_next;
    out_tmo    <= out_tmo_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= mft_pkg::BK_IDLE;
      head_slot      <= '0;
      tail_slot      <= '0;
      queue_empty    <= 1'b1;
      queue_full     <= 1'b0;
      bytes_gathered <= '0;
      push_rejected  <= mft_pkg::ST_OK;
      out_valid      <= 1'b0;
    end else begin
      state          <= state_next;
      head_slot      <= head_slot_next;
      tail_slot      <= tail_slot_next;
      queue_empty    <= queue_empty_next;
      queue_full     <= queue_full_next;
      bytes_gathered <= bytes_gathered_next;
      push_rejected  <= push_rejected_next;
      out_valid      <= out_valid_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_tmo, out_len, out_byte};
  assign m_axis_tlast  = out_last;
  assign m_axis_tuser  = out_status;

  `MFT_ASSERT_NOW(a_full_empty_excl, clk, rst, queue_full, !queue_empty, "full and empty together")
  `MFT_ASSERT_NOW(a_full_ptrs, clk, rst, queue_full, head_slot == tail_slot, "full with pointers apart")
  `MFT_ASSERT_NOW(a_gather_bound, clk, rst, 1'b1, bytes_gathered <= LW'(mft_pkg::SLOT_BYTES), "gather count overrun")
  `MFT_ASSERT_NOW(a_pop_idx, clk, rst, state == mft_pkg::BK_POP, LW'(pop_idx) < pop_len, "pop index past length")
  `MFT_ASSERT_NEXT(a_pop_done, clk, rst, state == mft_pkg::BK_POP && out_free && pop_end, state == mft_pkg::BK_IDLE && m_axis_tlast, "pop end not closed")

endmodule

>>> sv/message_fifo_with_timeout.sv
// ----------------------------------------------------------------------------
// message_fifo_with_timeout
// circular queue of whole messages, each with a length and a signed timeout
// ----------------------------------------------------------------------------
// push byte: one transaction per cycle unless a pop or output stall holds the back end;
// a closing byte's status is registered at the output; pop: first byte is registered from
// the store read, then one byte per cycle from the single read port while the output is free
// rst (synchronous) clears pointers, flags, gather count and command queue
// byte store and slot tables are not cleared; no clearing pass after reset
`timescale 1ns / 1ps

module message_fifo_with_timeout (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mft_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // data_byte, timeout_in
  input  logic                            s_axis_tlast,
  input  logic                            s_axis_tuser,   // func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mft_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // out_byte, msg_length, msg_timeout
  output logic                            m_axis_tlast,
  output logic [1:0]                      m_axis_tuser    // status
);

  logic          f_valid;
  logic          f_ready;
  mft_pkg::cmd_t f_cmd;
  logic          q_valid;
  logic          q_ready;
  mft_pkg::cmd_t q_cmd;

  mft_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .cmd_valid     (f_valid),
    .cmd_ready     (f_ready),
    .cmd           (f_cmd)
  );

  mft_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  mft_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (q_valid),
    .cmd_ready     (q_ready),
    .cmd           (q_cmd),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

>>> tb/tb_message_fifo_with_timeout.sv
// ----------------------------------------------------------------------------
// tb_message_fifo_with_timeout
// drives push and pop transactions into the message fifo and checks every
// output transaction against a cycle-free model of the queue kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_message_fifo_with_timeout;
  import mft_pkg::*;

  typedef enum logic [1:0] {
    REJ_NONE,
    REJ_FULL,
    REJ_LONG
  } reject_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [7:0]       data;
    logic             last;
    logic [LEN_W-1:0] len;
    logic [TMO_W-1:0] tmo;
  } msg_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // data_byte, timeout_in
  logic                  s_axis_tlast = 1'b0;
  logic                  s_axis_tuser = 1'b0; // func
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // out_byte, msg_length, msg_timeout
  logic                  m_axis_tlast;
  logic [1:0]            m_axis_tuser;        // status

  // queue model
  logic [7:0]       store_m [SLOT_COUNT*SLOT_BYTES];
  logic [LEN_W-1:0] slot_len_m [SLOT_COUNT];
  logic [TMO_W-1:0] slot_tmo_m [SLOT_COUNT];
  logic [SLOT_W-1:0] head_m = '0;
  logic [SLOT_W-1:0] tail_m = '0;
  logic              empty_m = 1'b1;
  logic              full_m = 1'b0;
  logic [LEN_W-1:0]  gathered_m = '0;
  reject_t           rejected_m = REJ_NONE;

  msg_word_t due_words[$];

  int src_idle_pct = 0;
  int sink_idle_pct = 0;
  int errors = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_pops = 0;
  int n_full = 0;
  int n_long = 0;
  int n_empty = 0;

  message_fifo_with_timeout i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #1 clk = ~clk;

  function automatic void fifo_predict(input logic fn, input logic [7:0] b, input logic lst,
                                       input logic [TMO_W-1:0] tmo);
    msg_word_t w;
    logic [SLOT_W-1:0] t;
    logic [LEN_W-1:0] n;
    int i;
    w = '0;
    if (fn == FUNC_PUSH) begin
      if (full_m) begin
        rejected_m = REJ_FULL;
      end else if (gathered_m >= SLOT_BYTES) begin
        if (rejected_m != REJ_FULL) rejected_m = REJ_LONG;
      end else begin
        store_m[head_m*SLOT_BYTES + gathered_m] = b;
        gathered_m = gathered_m + 1'b1;
      end
      if (lst) begin
        w.last = 1'b1;
        if (full_m || rejected_m == REJ_FULL) begin
          w.status = ST_FULL;
          n_full++;
        end else if (rejected_m == REJ_LONG) begin
          w.status = ST_LONG;
          n_long++;
        end else begin
          slot_len_m[head_m] = gathered_m;
          slot_tmo_m[head_m] = tmo;
          if (empty_m) tail_m = head_m;
          empty_m = 1'b0;
          head_m = SLOT_W'((head_m + 1) % SLOT_COUNT);
          if (head_m == tail_m) full_m = 1'b1;
          w.status = ST_OK;
        end
        gathered_m = '0;
        rejected_m = REJ_NONE;
        due_words.push_back(w);
      end
    end else begin
      n_pops++;
      if (empty_m) begin
        w.status = ST_EMPTY;
        w.last = 1'b1;
        n_empty++;
        due_words.push_back(w);
      end else begin
        t = tail_m;
        n = slot_len_m[t];
        for (i = 0; i < n; i++) begin
          w.status = ST_OK;
          w.data = store_m[t*SLOT_BYTES + i];
          w.last = (i == n - 1);
          w.len = n;
          w.tmo = slot_tmo_m[t];
          due_words.push_back(w);
        end
        full_m = 1'b0;
        tail_m = SLOT_W'((t + 1) % SLOT_COUNT);
        if (tail_m == head_m) empty_m = 1'b1;
      end
    end
  endfunction

  task automatic send_item(input logic fn, input logic [7:0] b, input logic lst,
                           input logic [TMO_W-1:0] tmo);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= fn;
    s_axis_tlast <= lst;
    s_axis_tdata <= {tmo, b};
    do @(posedge clk); while (!s_axis_tready);
    fifo_predict(fn, b, lst, tmo);
    n_sent++;
  endtask

  task automatic send_pop();
    send_item(FUNC_POP, 8'($urandom), 1'($urandom), $urandom);
  endtask

  // message of n bytes, with optional pops slipped in before its bytes
  task automatic push_message(input int n, input int mid_pop_pct);
    int i;
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < mid_pop_pct) send_pop();
      send_item(FUNC_PUSH, 8'($urandom), i == n - 1, $urandom);
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (due_words.size() != 0) @(posedge clk);
  endtask

  task automatic test_empty_pop();
    send_pop();
    send_item(FUNC_PUSH, 8'($urandom), 1'b0, $urandom);
    send_pop();
    send_item(FUNC_PUSH, 8'($urandom), 1'b1, $urandom);
  endtask

  task automatic test_field_extremes();
    send_item(FUNC_PUSH, 8'h00, 1'b1, 32'h8000_0000);
    send_item(FUNC_PUSH, 8'hff, 1'b1, 32'h7fff_ffff);
  endtask

  task automatic test_pop_mid_push();
    send_item(FUNC_PUSH, 8'($urandom), 1'b0, $urandom);
    send_pop();
    send_item(FUNC_PUSH, 8'($urandom), 1'b1, $urandom);
  endtask

  task automatic test_queue_full();
    while (!full_m) push_message(1, 0);
    // byte while full, then room appears before the closing byte
    send_item(FUNC_PUSH, 8'($urandom), 1'b0, $urandom);
    send_pop();
    send_item(FUNC_PUSH, 8'($urandom), 1'b1, $urandom);
    push_message(1, 0);
    send_pop();
  endtask

  task automatic test_long_messages();
    while (!empty_m) send_pop();
    push_message(SLOT_BYTES, 0);
    push_message(SLOT_BYTES + 1, 0);
    send_pop();
    // full recorded, then an oversized message once room is back
    while (!full_m) push_message(1, 0);
    send_item(FUNC_PUSH, 8'($urandom), 1'b0, $urandom);
    send_pop();
    push_message(SLOT_BYTES + 1, 0);
    while (!empty_m) send_pop();
  endtask

  task automatic test_random_traffic(input int count);
    int goal;
    int pop_pct;
    int r;
    goal = n_sent + count;
    pop_pct = 35;
    while (n_sent < goal) begin
      if ($urandom_range(29) == 0) begin
        case ($urandom_range(2))
          0: pop_pct = 15;
          1: pop_pct = 35;
          default: pop_pct = 60;
        endcase
      end
      r = $urandom_range(99);
      if (r < pop_pct) begin
        send_pop();
      end else if (r < pop_pct + 5) begin
        send_item(FUNC_PUSH, 8'($urandom), 1'($urandom), $urandom);
      end else if ($urandom_range(9) == 0) begin
        push_message($urandom_range(SLOT_BYTES - 4, SLOT_BYTES + 4), 5);
      end else begin
        push_message($urandom_range(1, 6), 5);
      end
    end
  endtask

  function automatic void check_field(input string what, input logic [31:0] exp,
                                      input logic [31:0] act);
    if (exp !== act) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, exp, act);
    end
  endfunction

  always @(posedge clk) begin : result_check
    msg_word_t w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_results++;
      if (due_words.size() == 0) begin
        errors++;
        $display("%0t: unexpected transaction, expected none, actual tdata 0x%0h tuser %0d",
                 $time, m_axis_tdata, m_axis_tuser);
      end else begin
        w = due_words.pop_front();
        check_field("status", w.status, m_axis_tuser);
        check_field("out_byte", w.data, m_axis_tdata[7:0]);
        check_field("out_last", w.last, m_axis_tlast);
        check_field("msg_length", w.len, m_axis_tdata[8 +: LEN_W]);
        check_field("msg_timeout", w.tmo, m_axis_tdata[8 + LEN_W +: TMO_W]);
      end
    end
  end

  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_idle_pct = 11;
    sink_idle_pct = 85;
    test_empty_pop();
    test_field_extremes();
    test_pop_mid_push();
    test_queue_full();
    test_random_traffic(40);
    wait_drained();

    src_idle_pct = 85;
    sink_idle_pct = 11;
    test_long_messages();
    test_random_traffic(40);
    wait_drained();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(40);
    wait_drained();
    repeat (40) @(posedge clk);

    $display("covered %0d input and %0d output transactions over %0d pops",
             n_sent, n_results, n_pops);
    $display("statuses seen: %0d queue full, %0d too long, %0d queue empty",
             n_full, n_long, n_empty);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
